// ----- rtl/sector_cache_clock_replacement_top_macros.svh -----
// Assertion macros used by the sector cache controller RTL.
`ifndef SECTOR_CACHE_CLOCK_REPLACEMENT_TOP_MACROS_SVH
`define SECTOR_CACHE_CLOCK_REPLACEMENT_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// Property checked on every rising edge while reset is released.
`define SCCR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Property checked on every rising edge, reset included.
`define SCCR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SCCR_ASSERT(lbl, clk, rst_n, prop, msg)
`define SCCR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- rtl/sccr_pkg.sv -----
// Shared constants, request codes and the result type of the sector cache controller.
package sccr_pkg;

  localparam int ENTRIES     = 64;
  localparam int SECTOR_BITS = 32;
  localparam int SLOT_W      = $clog2(ENTRIES);
  localparam int IDX_W       = $clog2(ENTRIES + 1);
  localparam int WB_W        = 32;
  localparam int TYPE_W      = 2;

  localparam logic [TYPE_W-1:0] REQ_READ  = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_WRITE = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_FLUSH = 2'd2;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              hit;
    logic              need_fill;
    logic              need_writeback;
    logic [WB_W-1:0]   writeback_sector;
    logic              last;
  } result_t;

endpackage

// ----- rtl/sccr_tag_ram.sv -----
// Single-port-write, single-port-read tag memory with registered read data.
module sccr_tag_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// ----- rtl/sccr_out_reg.sv -----
// Output register that holds one result until the downstream side takes it.
module sccr_out_reg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push_valid,
  input  sccr_pkg::result_t              push_res,
  output logic                           push_ready,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [sccr_pkg::SLOT_W-1:0]    out_slot,
  output logic                           out_hit,
  output logic                           out_need_fill,
  output logic                           out_need_writeback,
  output logic [sccr_pkg::WB_W-1:0]      out_writeback_sector,
  output logic                           out_last
);

  logic              valid_r;
  sccr_pkg::result_t data_r;

  assign push_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push_valid && push_ready) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_valid && push_ready) begin
      data_r <= push_res;
    end
  end

  assign out_valid            = valid_r;
  assign out_slot             = data_r.slot;
  assign out_hit              = data_r.hit;
  assign out_need_fill        = data_r.need_fill;
  assign out_need_writeback   = data_r.need_writeback;
  assign out_writeback_sector = data_r.writeback_sector;
  assign out_last             = data_r.last;

endmodule

// ----- rtl/sccr_ctrl.sv -----
// Lookup, clock sweep and flush sequencer with the valid, dirty and reference flags.
`include "sector_cache_clock_replacement_top_macros.svh"

module sccr_ctrl (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [sccr_pkg::TYPE_W-1:0]          in_req_type,
  input  logic [31:0]                          in_sector,
  output logic                                 ram_we,
  output logic [sccr_pkg::SLOT_W-1:0]          ram_waddr,
  output logic [sccr_pkg::SECTOR_BITS-1:0]     ram_wdata,
  output logic                                 ram_re,
  output logic [sccr_pkg::SLOT_W-1:0]          ram_raddr,
  input  logic [sccr_pkg::SECTOR_BITS-1:0]     ram_rdata,
  output logic                                 push_valid,
  output sccr_pkg::result_t                    push_res,
  input  logic                                 push_ready
);

  localparam int N  = sccr_pkg::ENTRIES;
  localparam int SW = sccr_pkg::SLOT_W;
  localparam int IW = sccr_pkg::IDX_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOOK  = 3'd1;
  localparam logic [2:0] S_SWEEP = 3'd2;
  localparam logic [2:0] S_VREAD = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;
  localparam logic [2:0] S_FREAD = 3'd5;
  localparam logic [2:0] S_RES   = 3'd6;

  logic [2:0]                       state_r, state_nxt;
  logic [2:0]                       ret_r, ret_nxt;
  logic [sccr_pkg::TYPE_W-1:0]      type_r, type_nxt;
  logic [sccr_pkg::SECTOR_BITS-1:0] sec_r, sec_nxt;
  logic [IW-1:0]                    idx_r, idx_nxt;
  logic                             chk_v_r, chk_v_nxt;
  logic [SW-1:0]                    chk_idx_r, chk_idx_nxt;
  logic [SW-1:0]                    hand_r, hand_nxt;
  logic [SW-1:0]                    victim_r, victim_nxt;
  logic                             found_r, found_nxt;
  logic [N-1:0]                     valid_r, valid_nxt;
  logic [N-1:0]                     dirty_r, dirty_nxt;
  logic [N-1:0]                     ref_r, ref_nxt;
  sccr_pkg::result_t                res_r, res_nxt;

  logic          chk_hit;
  logic          chk_last;
  logic [SW-1:0] hand_inc;
  logic          wb;
  logic [N-1:0]  later_mask;
  logic          more_dirty;

  assign chk_hit  = chk_v_r && valid_r[chk_idx_r] && (ram_rdata == sec_r);
  assign chk_last = chk_v_r && (chk_idx_r == SW'(N - 1));
  assign hand_inc = (hand_r == SW'(N - 1)) ? '0 : hand_r + 1'b1;
  assign wb       = valid_r[victim_r] && dirty_r[victim_r];

  // Dirty entries strictly above the one being written back decide the last flag.
  assign later_mask = ~((N'(2) << victim_r) - N'(1));
  assign more_dirty = |(dirty_r & later_mask);

  assign in_ready   = (state_r == S_IDLE);
  assign push_valid = (state_r == S_RES);
  assign push_res   = res_r;

  always_comb begin
    state_nxt   = state_r;
    ret_nxt     = ret_r;
    type_nxt    = type_r;
    sec_nxt     = sec_r;
    idx_nxt     = idx_r;
    chk_v_nxt   = 1'b0;
    chk_idx_nxt = chk_idx_r;
    hand_nxt    = hand_r;
    victim_nxt  = victim_r;
    found_nxt   = found_r;
    valid_nxt   = valid_r;
    dirty_nxt   = dirty_r;
    ref_nxt     = ref_r;
    res_nxt     = res_r;
    ram_we      = 1'b0;
    ram_waddr   = victim_r;
    ram_wdata   = sec_r;
    ram_re      = 1'b0;
    ram_raddr   = victim_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          type_nxt  = in_req_type;
          sec_nxt   = in_sector[sccr_pkg::SECTOR_BITS-1:0];
          idx_nxt   = '0;
          found_nxt = 1'b0;
          case (in_req_type) inside
            sccr_pkg::REQ_FLUSH:                     state_nxt = S_FLUSH;
            sccr_pkg::REQ_READ, sccr_pkg::REQ_WRITE: state_nxt = S_LOOK;
            default:                                 state_nxt = S_IDLE;
          endcase
        end
      end
      S_LOOK: begin
        if (chk_hit) begin
          res_nxt = '{slot: chk_idx_r, hit: 1'b1, need_fill: 1'b0, need_writeback: 1'b0,
                      writeback_sector: '0, last: 1'b1};
          ref_nxt[chk_idx_r] = 1'b1;
          if (type_r == sccr_pkg::REQ_WRITE) begin
            dirty_nxt[chk_idx_r] = 1'b1;
          end
          ret_nxt   = S_IDLE;
          state_nxt = S_RES;
        end else if (chk_last) begin
          state_nxt = S_SWEEP;
        end else if (idx_r < IW'(N)) begin
          ram_re      = 1'b1;
          ram_raddr   = idx_r[SW-1:0];
          chk_v_nxt   = 1'b1;
          chk_idx_nxt = idx_r[SW-1:0];
          idx_nxt     = idx_r + 1'b1;
        end
      end
      S_SWEEP: begin
        hand_nxt = hand_inc;
        if (ref_r[hand_r]) begin
          ref_nxt[hand_r] = 1'b0;
        end else begin
          victim_nxt = hand_r;
          ram_re     = 1'b1;
          ram_raddr  = hand_r;
          state_nxt  = S_VREAD;
        end
      end
      S_VREAD: begin
        res_nxt = '{slot: victim_r, hit: 1'b0, need_fill: 1'b1, need_writeback: wb,
                    writeback_sector: wb ? sccr_pkg::WB_W'(ram_rdata) : '0, last: 1'b1};
        ram_we              = 1'b1;
        ram_waddr           = victim_r;
        ram_wdata           = sec_r;
        valid_nxt[victim_r] = 1'b1;
        ref_nxt[victim_r]   = 1'b1;
        dirty_nxt[victim_r] = (type_r == sccr_pkg::REQ_WRITE);
        ret_nxt             = S_IDLE;
        state_nxt           = S_RES;
      end
      S_FLUSH: begin
        if (idx_r == IW'(N)) begin
          if (found_r) begin
            state_nxt = S_IDLE;
          end else begin
            res_nxt = '{slot: '0, hit: 1'b0, need_fill: 1'b0, need_writeback: 1'b0,
                        writeback_sector: '0, last: 1'b1};
            ret_nxt   = S_IDLE;
            state_nxt = S_RES;
          end
        end else if (dirty_r[idx_r[SW-1:0]]) begin
          ram_re     = 1'b1;
          ram_raddr  = idx_r[SW-1:0];
          victim_nxt = idx_r[SW-1:0];
          state_nxt  = S_FREAD;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_FREAD: begin
        res_nxt = '{slot: victim_r, hit: 1'b0, need_fill: 1'b0, need_writeback: 1'b1,
                    writeback_sector: sccr_pkg::WB_W'(ram_rdata), last: !more_dirty};
        dirty_nxt[victim_r] = 1'b0;
        found_nxt           = 1'b1;
        idx_nxt             = idx_r + 1'b1;
        ret_nxt             = S_FLUSH;
        state_nxt           = S_RES;
      end
      S_RES: begin
        if (push_ready) begin
          state_nxt = ret_r;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
      chk_v_r <= 1'b0;
      hand_r  <= '0;
      found_r <= 1'b0;
      valid_r <= '0;
      dirty_r <= '0;
      ref_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      chk_v_r <= chk_v_nxt;
      hand_r  <= hand_nxt;
      found_r <= found_nxt;
      valid_r <= valid_nxt;
      dirty_r <= dirty_nxt;
      ref_r   <= ref_nxt;
    end
  end

  always_ff @(posedge clk) begin
    type_r    <= type_nxt;
    sec_r     <= sec_nxt;
    idx_r     <= idx_nxt;
    chk_idx_r <= chk_idx_nxt;
    victim_r  <= victim_nxt;
    res_r     <= res_nxt;
  end

  `SCCR_ASSERT(a_sweep_moves_hand, clk, rst_n, (state_r == S_SWEEP) |=> (hand_r != $past(hand_r)), "clock hand stalled during sweep")
  `SCCR_ASSERT(a_victim_unreferenced, clk, rst_n, (state_r == S_VREAD) |-> !ref_r[victim_r], "victim has its reference flag set")
  `SCCR_ASSERT(a_flush_entry_dirty, clk, rst_n, (state_r == S_FREAD) |-> dirty_r[victim_r], "flush writes back a clean entry")
  `SCCR_ASSERT(a_dirty_needs_valid, clk, rst_n, (dirty_r & ~valid_r) == '0, "dirty flag set on an invalid entry")

endmodule

// ----- rtl/sector_cache_clock_replacement_top.sv -----
// A hit is found by reading the tags in ascending slot order until one matches.
// A miss adds a clock sweep for the victim and a read of the victim's tag.
// Flush: walks the dirty flags and reads the tag of each dirty entry; one request is handled at a time.
// The next request is taken only once the sequencer is idle again, after its last result
// has entered the output register; the tag RAM scan sets how long that wait is.
// Reset (synchronous, active low) clears the flags and clock hand; tags stay, qualified by valid.
module sector_cache_clock_replacement_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [sccr_pkg::TYPE_W-1:0]       in_req_type,
  input  logic [31:0]                       in_sector,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [sccr_pkg::SLOT_W-1:0]       out_slot,
  output logic                              out_hit,
  output logic                              out_need_fill,
  output logic                              out_need_writeback,
  output logic [sccr_pkg::WB_W-1:0]         out_writeback_sector,
  output logic                              out_last
);

  // Tag RAM access from the sequencer. The sequencer never reads and writes the
  // same entry in overlapping cycles, since each access stage waits in its own state.
  logic                             ram_we;
  logic [sccr_pkg::SLOT_W-1:0]      ram_waddr;
  logic [sccr_pkg::SECTOR_BITS-1:0] ram_wdata;
  logic                             ram_re;
  logic [sccr_pkg::SLOT_W-1:0]      ram_raddr;
  logic [sccr_pkg::SECTOR_BITS-1:0] ram_rdata;

  // Finished results travel from the sequencer to the output register, which
  // lets the next request enter while a result still waits to be taken.
  logic              push_valid;
  logic              push_ready;
  sccr_pkg::result_t push_res;

  sccr_tag_ram #(
    .DEPTH (sccr_pkg::ENTRIES),
    .WIDTH (sccr_pkg::SECTOR_BITS)
  ) u_tag_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (ram_re),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata)
  );

  // The sequencer scans the tags for a hit, sweeps the clock hand on a miss,
  // and walks the dirty flags on a flush, emitting one result at a time.
  sccr_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .in_sector   (in_sector),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .push_valid  (push_valid),
    .push_res    (push_res),
    .push_ready  (push_ready)
  );

  sccr_out_reg u_out_reg (
    .clk                  (clk),
    .rst_n                (rst_n),
    .push_valid           (push_valid),
    .push_res             (push_res),
    .push_ready           (push_ready),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_slot             (out_slot),
    .out_hit              (out_hit),
    .out_need_fill        (out_need_fill),
    .out_need_writeback   (out_need_writeback),
    .out_writeback_sector (out_writeback_sector),
    .out_last             (out_last)
  );

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the clock-replacement sector cache controller.
`timescale 1ns / 1ps

module tb;
  import sccr_pkg::*;

  // Type code that the block must ignore without producing any reply.
  localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;

  localparam logic [31:0] SEC_MASK =
    (SECTOR_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << SECTOR_BITS) - 1);

  localparam int N_RANDOM    = 340;
  localparam int POOL_SIZE   = 100;
  localparam int HOLD_AT     = 40;
  localparam int HOLD_CYCLES = 600;
  localparam int DRAIN_WAIT  = 3 * ENTRIES;
  localparam int STALL_LIMIT = 5000;
  localparam int MAX_REPORTS = 10;

  // One request as queued for the driver, with the idling mix of its phase.
  typedef struct {
    logic [TYPE_W-1:0] rtype;
    logic [31:0]       sector;
    int                send_idle_pct;
    int                recv_stall_pct;
  } sector_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [TYPE_W-1:0]    in_req_type = '0;
  logic [31:0]          in_sector = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [SLOT_W-1:0]    out_slot;
  logic                 out_hit;
  logic                 out_need_fill;
  logic                 out_need_writeback;
  logic [WB_W-1:0]      out_writeback_sector;
  logic                 out_last;

  sector_cache_clock_replacement_top dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_req_type          (in_req_type),
    .in_sector            (in_sector),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_slot             (out_slot),
    .out_hit              (out_hit),
    .out_need_fill        (out_need_fill),
    .out_need_writeback   (out_need_writeback),
    .out_writeback_sector (out_writeback_sector),
    .out_last             (out_last)
  );

  // 8 ns clock period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Requests waiting for the driver and replies waiting for the block.
  sector_req_t sector_requests[$];
  result_t     predicted_replies[$];

  // Shadow copy of the cache tag and policy state, cleared as after reset.
  logic [31:0]       shadow_tag   [ENTRIES] = '{default: '0};
  bit                shadow_valid [ENTRIES];
  bit                shadow_dirty [ENTRIES];
  bit                shadow_refd  [ENTRIES];
  int                shadow_hand;

  int n_total;
  int n_in;
  int n_offered;
  int n_out;
  int n_errors;
  int recv_stall_pct = 0;
  int hold_left;
  bit hold_done;
  int quiet_cycles;

  // Tallies for the closing summary.
  int n_hits, n_misses, n_evict_wb, n_flushes, n_flush_wb, n_ignored;

  logic [31:0] sector_pool[POOL_SIZE];

  task automatic report_error(input string what);
    n_errors++;
    if (n_errors <= MAX_REPORTS) $display("ERROR @%0t: %s", $time, what);
  endtask

  // Works out the replies for one accepted request and updates the shadow state.
  // A hit marks the slot referenced (and dirty on a write). A miss runs the clock
  // hand: referenced slots get their flag cleared and are skipped, the first clear
  // slot becomes the victim, and the hand always steps past every slot it visits.
  // A flush walks the slots in ascending order and cleans every dirty one.
  task automatic predict_cache_access(input logic [TYPE_W-1:0] rtype,
                                      input logic [31:0] raw_sector);
    logic [31:0] sec;
    result_t     reply;
    result_t     flush_replies[$];
    int          hit_slot;
    int          victim;
    sec = raw_sector & SEC_MASK;
    reply = '0;
    if (rtype == REQ_UNUSED) begin
      n_ignored++;
      return;
    end
    if (rtype == REQ_FLUSH) begin
      n_flushes++;
      for (int i = 0; i < ENTRIES; i++) begin
        if (shadow_dirty[i]) begin
          reply = '0;
          reply.slot = SLOT_W'(i);
          reply.need_writeback = 1'b1;
          reply.writeback_sector = shadow_tag[i];
          flush_replies.push_back(reply);
          shadow_dirty[i] = 1'b0;
          n_flush_wb++;
        end
      end
      if (flush_replies.size() == 0) begin
        // Nothing dirty: a single reply that asks for no write-back.
        reply = '0;
        reply.last = 1'b1;
        predicted_replies.push_back(reply);
      end else begin
        flush_replies[flush_replies.size() - 1].last = 1'b1;
        foreach (flush_replies[k]) predicted_replies.push_back(flush_replies[k]);
      end
      return;
    end
    hit_slot = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit_slot < 0 && shadow_valid[i] && shadow_tag[i] == sec) hit_slot = i;
    end
    if (hit_slot >= 0) begin
      n_hits++;
      shadow_refd[hit_slot] = 1'b1;
      if (rtype == REQ_WRITE) shadow_dirty[hit_slot] = 1'b1;
      reply.slot = SLOT_W'(hit_slot);
      reply.hit  = 1'b1;
      reply.last = 1'b1;
      predicted_replies.push_back(reply);
      return;
    end
    n_misses++;
    victim = -1;
    for (int g = 0; g <= ENTRIES && victim < 0; g++) begin
      int i;
      i = shadow_hand;
      shadow_hand = (i + 1) % ENTRIES;
      if (shadow_refd[i]) shadow_refd[i] = 1'b0;
      else victim = i;
    end
    if (victim < 0) victim = shadow_hand;
    reply.slot = SLOT_W'(victim);
    reply.need_fill = 1'b1;
    reply.last = 1'b1;
    if (shadow_valid[victim] && shadow_dirty[victim]) begin
      reply.need_writeback = 1'b1;
      reply.writeback_sector = shadow_tag[victim];
      n_evict_wb++;
    end
    shadow_tag[victim]   = sec;
    shadow_valid[victim] = 1'b1;
    shadow_refd[victim]  = 1'b1;
    shadow_dirty[victim] = (rtype == REQ_WRITE);
    predicted_replies.push_back(reply);
  endtask

  task automatic check_reply();
    result_t want;
    if (predicted_replies.size() == 0) begin
      report_error($sformatf({"reply with nothing expected: slot %0d hit %0b fill %0b ",
                              "wb %0b sec %h last %0b"},
                             out_slot, out_hit, out_need_fill, out_need_writeback,
                             out_writeback_sector, out_last));
      return;
    end
    want = predicted_replies.pop_front();
    if (out_slot !== want.slot || out_hit !== want.hit || out_need_fill !== want.need_fill ||
        out_need_writeback !== want.need_writeback ||
        out_writeback_sector !== want.writeback_sector || out_last !== want.last) begin
      report_error($sformatf({"reply %0d mismatch: expected slot %0d hit %0b fill %0b wb %0b ",
                              "sec %h last %0b, got slot %0d hit %0b fill %0b ",
                              "wb %0b sec %h last %0b"},
                             n_out, want.slot, want.hit, want.need_fill, want.need_writeback,
                             want.writeback_sector, want.last, out_slot, out_hit, out_need_fill,
                             out_need_writeback, out_writeback_sector, out_last));
    end
  endtask

  task automatic queue_request(input logic [TYPE_W-1:0] rtype, input logic [31:0] sector,
                               input int send_idle, input int recv_stall);
    sector_req_t r;
    r.rtype = rtype;
    r.sector = sector;
    r.send_idle_pct = send_idle;
    r.recv_stall_pct = recv_stall;
    sector_requests.push_back(r);
  endtask

  // Sampling at the rising edge: replies are checked first, then an accepted
  // request is run through the shadow state so its replies queue up behind the
  // ones already outstanding.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        check_reply();
        n_out++;
      end
      if (in_valid && in_ready) begin
        predict_cache_access(in_req_type, in_sector);
        n_in++;
      end
    end
  end

  // Request driver, stepping at the falling edge. A request stays on the port,
  // unchanged, until the sampling process has counted it as accepted; only then
  // is the next one offered or the port left idle.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || n_in == n_offered) begin
      if (sector_requests.size() > 0 &&
          $urandom_range(99) >= sector_requests[0].send_idle_pct) begin
        sector_req_t r;
        r = sector_requests.pop_front();
        in_valid       <= 1'b1;
        in_req_type    <= r.rtype;
        in_sector      <= r.sector;
        recv_stall_pct <= r.recv_stall_pct;
        n_offered++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Reply acceptance. Once, early in the run, the receiver holds off for a long
  // stretch while the driver keeps offering requests, so the block backs up and
  // has to drop in_ready.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && n_in >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: too many cycles in a row with no request or reply accepted.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("Timeout after %0d cycles without progress", quiet_cycles);
        $display("FAILED: results differ");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int phase;
    int send_idle;
    int recv_stall;
    int pick;
    logic [TYPE_W-1:0] rtype;
    logic [31:0] sector;

    // Directed requests, no idling. Sector zero misses first, since no tag is
    // valid after reset, whatever it holds. Flushes are tried both with and without
    // dirty slots, and the unused type code must leave no trace.
    queue_request(REQ_READ,   32'h0000_0000, 0, 0);
    queue_request(REQ_READ,   32'h0000_0000, 0, 0);
    queue_request(REQ_FLUSH,  32'h0000_0000, 0, 0);
    queue_request(REQ_WRITE,  32'hFFFF_FFFF, 0, 0);
    queue_request(REQ_WRITE,  32'h0000_0000, 0, 0);
    queue_request(REQ_UNUSED, 32'hFFFF_FFFF, 0, 0);
    queue_request(REQ_FLUSH,  32'hFFFF_FFFF, 0, 0);
    queue_request(REQ_FLUSH,  32'h0000_0000, 0, 0);
    queue_request(REQ_WRITE,  32'hAAAA_5555, 0, 0);
    queue_request(REQ_WRITE,  32'h5555_AAAA, 0, 0);
    queue_request(REQ_READ,   32'h8000_0000, 0, 0);
    queue_request(REQ_WRITE,  32'h0000_0001, 0, 0);
    queue_request(REQ_READ,   32'hAAAA_5555, 0, 0);
    queue_request(REQ_WRITE,  32'hFFFF_FFFF, 0, 0);
    queue_request(REQ_UNUSED, 32'h0000_0000, 0, 0);
    queue_request(REQ_READ,   32'hFFFF_FFFF, 0, 0);
    queue_request(REQ_FLUSH,  32'h1234_5678, 0, 0);

    // A working set somewhat larger than the cache, so the random part sees
    // hits, a full cache, clock sweeps and evictions of dirty slots.
    foreach (sector_pool[i]) begin
      if (i < POOL_SIZE / 4) sector_pool[i] = 32'(i);
      else sector_pool[i] = $urandom;
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      phase = (n * 4) / N_RANDOM;
      case (phase)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 47; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 47; end
        default: begin send_idle = 31; recv_stall = 31; end
      endcase
      pick = $urandom_range(99);
      if (pick < 45)      rtype = REQ_READ;
      else if (pick < 87) rtype = REQ_WRITE;
      else if (pick < 95) rtype = REQ_FLUSH;
      else                rtype = REQ_UNUSED;
      if ($urandom_range(99) < 85) sector = sector_pool[$urandom_range(POOL_SIZE - 1)];
      else sector = $urandom;
      queue_request(rtype, sector, send_idle, recv_stall);
    end
    n_total = sector_requests.size();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Every request accepted, every reply in, then a quiet spell long enough
    // for a stray reply to show up.
    wait (n_in == n_total);
    wait (predicted_replies.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);

    while (predicted_replies.size() > 0) begin
      result_t left;
      left = predicted_replies.pop_front();
      report_error($sformatf("reply never arrived: slot %0d wb %0b last %0b",
                             left.slot, left.need_writeback, left.last));
    end

    $display("Ran %0d requests: %0d hits, %0d misses (%0d evicting a dirty slot), %0d ignored.",
             n_in, n_hits, n_misses, n_evict_wb, n_ignored);
    $display("%0d flushes wrote back %0d slots; %0d replies checked, %0d errors.",
             n_flushes, n_flush_wb, n_out, n_errors);
    if (n_errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/sccr_pkg.sv
rtl/sccr_tag_ram.sv
rtl/sccr_out_reg.sv
rtl/sccr_ctrl.sv
rtl/sector_cache_clock_replacement_top.sv
tb/tb.sv
